/* rtl/core/ssd_pkg.sv */
// Shared types and constants for the serialized string decoder.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package ssd_pkg;

   localparam int BYTE_W  = 8;
   localparam int UNIT_W  = 16;
   localparam int ACCUM_W = 64;

   localparam int COMPRESSOR_BITS_DEF = 3;
   localparam int COUNT_BITS_DEF      = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef logic [ACCUM_W-1:0] accum_type;

   // Pending UTF continuation bytes
   localparam logic [1:0] CONT_NONE = 2'd0;
   localparam logic [1:0] CONT_ONE  = 2'd1;
   localparam logic [1:0] CONT_TWO  = 2'd2;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_ASCII  = 2'd1,
      PH_UTF    = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      RK_CHAR     = 2'd0,
      RK_EMPTY    = 2'd1,
      RK_BAD_COMP = 2'd2,
      RK_BAD_CHAR = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [UNIT_W-1:0] unit;
      logic              last;
   } rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

/* rtl/core/ssd_front.sv */
// Front end: accepts stream bytes, parses header and characters, pushes result records.
// Depends on ssd_pkg; feeds ssd_queue.
`default_nettype none

module ssd_front
   import ssd_pkg::*;
#(
   parameter int COMPRESSOR_BITS = COMPRESSOR_BITS_DEF,
   parameter int COUNT_BITS      = COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [BYTE_W-1:0] req_byte_value,
   output logic              req_stall,
   input  q_status_type      q_status,
   output logic              push,
   output rec_type           push_rec
);

   localparam int SHIFT  = COMPRESSOR_BITS + 1;
   localparam int HI_POS = SHIFT + COUNT_BITS;
   localparam accum_type CMASK = (accum_type'(1) << COMPRESSOR_BITS) - accum_type'(1);
   localparam accum_type HI_MASK =
      (HI_POS >= ACCUM_W) ? '0 : ~((accum_type'(1) << HI_POS) - accum_type'(1));
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   phase_type               phase_ff, phase_in;
   accum_type               accum_ff, accum_in;
   logic [COUNT_BITS-1:0]   chars_left_ff, chars_left_in;
   logic [UNIT_W-1:0]       partial_ff, partial_in;
   logic [1:0]              cont_ff, cont_in;

   logic                    accept;
   logic                    clear_all;
   accum_type               accum_next;
   accum_type               shifted;
   logic [COUNT_BITS-1:0]   chars_dec;
   logic                    string_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         accum_ff      <= '0;
         chars_left_ff <= '0;
         partial_ff    <= '0;
         cont_ff       <= CONT_NONE;
      end else begin
         phase_ff      <= phase_in;
         accum_ff      <= accum_in;
         chars_left_ff <= chars_left_in;
         partial_ff    <= partial_in;
         cont_ff       <= cont_in;
      end
   end

   always_comb begin
      req_stall   = q_status.full;
      accept      = req_valid && !q_status.full;
      accum_next  = {accum_ff[ACCUM_W-8:0], req_byte_value[6:0]};
      shifted     = accum_next >> SHIFT;
      chars_dec   = chars_left_ff - {{(COUNT_BITS-1){1'b0}}, (chars_left_ff != '0)};
      string_done = (chars_dec == '0);

      phase_in      = phase_ff;
      accum_in      = accum_ff;
      chars_left_in = chars_left_ff;
      partial_in    = partial_ff;
      cont_in       = cont_ff;
      clear_all     = 1'b0;
      push          = 1'b0;
      push_rec      = '{kind: RK_CHAR, unit: '0, last: 1'b0};

      if (accept) begin
         case (phase_ff)
            PH_ASCII: begin
               push          = 1'b1;
               push_rec.unit = UNIT_W'(req_byte_value[6:0]);
               push_rec.last = req_byte_value[7];
               clear_all     = req_byte_value[7];
            end
            PH_UTF: begin
               case (cont_ff)
                  CONT_TWO: begin
                     partial_in = partial_ff | {4'b0, req_byte_value[5:0], 6'b0};
                     cont_in    = CONT_ONE;
                  end
                  CONT_ONE: begin
                     push          = 1'b1;
                     push_rec.unit = partial_ff | {10'b0, req_byte_value[5:0]};
                     push_rec.last = string_done;
                     partial_in    = '0;
                     cont_in       = CONT_NONE;
                     chars_left_in = chars_dec;
                     clear_all     = string_done;
                  end
                  default: begin
                     if (!req_byte_value[7]) begin
                        push          = 1'b1;
                        push_rec.unit = UNIT_W'(req_byte_value);
                        push_rec.last = string_done;
                        chars_left_in = chars_dec;
                        clear_all     = string_done;
                     end else if (req_byte_value[7:5] == 3'b110) begin
                        partial_in = {5'b0, req_byte_value[4:0], 6'b0};
                        cont_in    = CONT_ONE;
                     end else if (req_byte_value[7:4] == 4'hE) begin
                        partial_in = {req_byte_value[3:0], 12'b0};
                        cont_in    = CONT_TWO;
                     end else begin
                        // invalid lead byte still counts as one character
                        push          = 1'b1;
                        push_rec.kind = RK_BAD_CHAR;
                        push_rec.last = string_done;
                        chars_left_in = chars_dec;
                        clear_all     = string_done;
                     end
                  end
               endcase
            end
            default: begin
               accum_in = accum_next;
               if (req_byte_value[7]) begin
                  if (accum_next == '0) begin
                     push          = 1'b1;
                     push_rec.kind = RK_EMPTY;
                     push_rec.last = 1'b1;
                     clear_all     = 1'b1;
                  end else if ((accum_next & CMASK) != '0) begin
                     push          = 1'b1;
                     push_rec.kind = RK_BAD_COMP;
                     push_rec.last = 1'b1;
                     clear_all     = 1'b1;
                  end else begin
                     accum_in   = '0;
                     partial_in = '0;
                     cont_in    = CONT_NONE;
                     if (!shifted[0]) begin
                        phase_in = PH_ASCII;
                     end else begin
                        phase_in      = PH_UTF;
                        // saturate counts that do not fit the counter
                        chars_left_in = ((accum_next & HI_MASK) != '0) ?
                                        COUNT_MAX : shifted[COUNT_BITS-1:0];
                     end
                  end
               end
            end
         endcase

         if (clear_all) begin
            phase_in      = PH_HEADER;
            accum_in      = '0;
            chars_left_in = '0;
            partial_in    = '0;
            cont_in       = CONT_NONE;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/core/ssd_queue.sv */
// Short result queue between the parser front end and the output stage.
// Depends on ssd_pkg.
`default_nettype none

module ssd_queue
   import ssd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rec_type      push_rec,
   input  logic         pop,
   output rec_type      head_rec,
   output q_status_type q_status
);

   rec_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
      q_status.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      q_status.empty = (count_ff == '0);
      head_rec       = entry_ff[rd_ptr_ff];
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("queue written while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

`default_nettype wire

/* rtl/core/ssd_back.sv */
// Output stage: takes records from the queue and presents them as result fields.
// Depends on ssd_pkg; reads ssd_queue.
`default_nettype none

module ssd_back
   import ssd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  q_status_type      q_status,
   input  rec_type           head_rec,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [UNIT_W-1:0] rsp_code_unit,
   output logic              rsp_last,
   output logic              rsp_empty_res,
   output logic              rsp_bad_compression,
   output logic              rsp_bad_char
);

   logic              valid_ff, valid_in;
   logic [UNIT_W-1:0] unit_ff, unit_in;
   logic              last_ff, last_in;
   logic              empty_ff, empty_in;
   logic              bad_comp_ff, bad_comp_in;
   logic              bad_char_ff, bad_char_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      unit_ff     <= unit_in;
      last_ff     <= last_in;
      empty_ff    <= empty_in;
      bad_comp_ff <= bad_comp_in;
      bad_char_ff <= bad_char_in;
   end

   always_comb begin
      // load when the output register is free or being taken
      pop         = !q_status.empty && (!valid_ff || !rsp_stall);
      valid_in    = pop || (valid_ff && rsp_stall);
      unit_in     = unit_ff;
      last_in     = last_ff;
      empty_in    = empty_ff;
      bad_comp_in = bad_comp_ff;
      bad_char_in = bad_char_ff;
      if (pop) begin
         unit_in     = (head_rec.kind == RK_CHAR) ? head_rec.unit : '0;
         last_in     = head_rec.last;
         empty_in    = (head_rec.kind == RK_EMPTY);
         bad_comp_in = (head_rec.kind == RK_BAD_COMP);
         bad_char_in = (head_rec.kind == RK_BAD_CHAR);
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_code_unit       = unit_ff;
   assign rsp_last            = last_ff;
   assign rsp_empty_res       = empty_ff;
   assign rsp_bad_compression = bad_comp_ff;
   assign rsp_bad_char        = bad_char_ff;

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_empty_res, rsp_bad_compression, rsp_bad_char}))
      else $error("more than one result flag set");

   a_header_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_empty_res || rsp_bad_compression)) |-> rsp_last)
      else $error("header result without last");

   a_flag_zero_unit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_empty_res || rsp_bad_compression || rsp_bad_char))
         |-> (rsp_code_unit == '0))
      else $error("flagged result carries a code unit");

endmodule

`default_nettype wire

/* rtl/core/serialized_string_decoder_top.sv */
// Serialized string decoder, top level.
// Instantiates ssd_front, ssd_queue and ssd_back; depends on ssd_pkg.
//
// Usage:
//   Request channel (req_valid / req_stall / req_byte_value) carries one raw
//   stream byte per request. Each string is a varint length header followed
//   by ASCII or UTF body bytes. Every request produces zero or one result.
//   Result channel (rsp_valid / rsp_stall / rsp_*) carries a decoded code
//   unit plus last, empty_res, bad_compression and bad_char flags.
//   Throughput: one request per cycle, sustained, while results are taken.
//   Path: the parser writes the four-entry queue at the edge that accepts
//   the request, and the output register loads from the queue once it is
//   free or being taken; rsp_valid rises as it loads.
//   Stall: while rsp_stall is high the output register holds; the queue
//   absorbs up to four more results, after which req_stall rises until
//   space frees up. req_stall depends only on the queue fill level.
//   Reset: synchronous; clears parser state, queue and output valid, and
//   the block is ready for a new header in the next cycle.
`default_nettype none

module serialized_string_decoder_top
   import ssd_pkg::*;
#(
   parameter int COMPRESSOR_BITS = COMPRESSOR_BITS_DEF,
   parameter int COUNT_BITS      = COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_byte_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [UNIT_W-1:0] rsp_code_unit,
   output logic              rsp_last,
   output logic              rsp_empty_res,
   output logic              rsp_bad_compression,
   output logic              rsp_bad_char
);

   q_status_type q_status;
   logic         push;
   rec_type      push_rec;
   logic         pop;
   rec_type      head_rec;

   ssd_front #(
      .COMPRESSOR_BITS (COMPRESSOR_BITS),
      .COUNT_BITS      (COUNT_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_byte_value (req_byte_value),
      .req_stall      (req_stall),
      .q_status       (q_status),
      .push           (push),
      .push_rec       (push_rec)
   );

   ssd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .q_status (q_status)
   );

   ssd_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_status            (q_status),
      .head_rec            (head_rec),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_code_unit       (rsp_code_unit),
      .rsp_last            (rsp_last),
      .rsp_empty_res       (rsp_empty_res),
      .rsp_bad_compression (rsp_bad_compression),
      .rsp_bad_char        (rsp_bad_char)
   );

endmodule

`default_nettype wire

/* verif/string_decode_checker.sv */
// Result checker for the serialized string decoder: decodes each accepted request
// byte on its own and compares every accepted result with the oldest expectation.
// Depends on ssd_pkg for widths, phases and continuation codes.
module string_decode_checker
   import ssd_pkg::*;
#(
   parameter int COMPRESSOR_BITS = COMPRESSOR_BITS_DEF,
   parameter int COUNT_BITS      = COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [BYTE_W-1:0] req_byte_value,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [UNIT_W-1:0] rsp_code_unit,
   input  logic              rsp_last,
   input  logic              rsp_empty_res,
   input  logic              rsp_bad_compression,
   input  logic              rsp_bad_char,
   output int                mismatch_count,
   output int                outstanding,
   output logic              at_string_start
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] LEAD_TWO_LO = 4'hC;
   localparam logic [3:0] LEAD_TWO_HI = 4'hD;
   localparam logic [3:0] LEAD_THREE  = 4'hE;
   localparam accum_type  COUNT_MAX   = (accum_type'(1) << COUNT_BITS) - 1;
   localparam int         MAX_PRINTED = 40;

   typedef struct packed {
      logic [UNIT_W-1:0] unit;
      logic              last;
      logic              empty_res;
      logic              bad_compression;
      logic              bad_char;
   } decoded_type;

   phase_type              phase;
   accum_type              accum;
   logic [COUNT_BITS-1:0]  chars_left;
   logic [UNIT_W-1:0]      partial_unit;
   logic [1:0]             cont_left;
   decoded_type            decoded_queue[$];

   initial begin
      mismatch_count  = 0;
      outstanding     = 0;
      at_string_start = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   task automatic restart();
      phase        = PH_HEADER;
      accum        = '0;
      chars_left   = '0;
      partial_unit = '0;
      cont_left    = CONT_NONE;
   endtask

   // Count one UTF character; true when it was the final one.
   function automatic logic count_char();
      if (chars_left != '0) chars_left = chars_left - 1'b1;
      return chars_left == '0;
   endfunction

   task automatic decode_byte(input logic [BYTE_W-1:0] b);
      decoded_type r;
      logic        emit;
      accum_type   v;
      r    = '0;
      emit = 1'b0;
      case (phase)
         PH_ASCII: begin
            r.unit = {9'd0, b[6:0]};
            r.last = b[7];
            emit   = 1'b1;
            if (b[7]) restart();
         end
         PH_UTF: begin
            if (cont_left == CONT_TWO) begin
               partial_unit = partial_unit | {4'd0, b[5:0], 6'd0};
               cont_left    = CONT_ONE;
            end else if (cont_left == CONT_ONE) begin
               r.unit       = partial_unit | {10'd0, b[5:0]};
               r.last       = count_char();
               emit         = 1'b1;
               partial_unit = '0;
               cont_left    = CONT_NONE;
            end else if (!b[7]) begin
               r.unit = {8'd0, b};
               r.last = count_char();
               emit   = 1'b1;
            end else if (b[7:4] == LEAD_TWO_LO || b[7:4] == LEAD_TWO_HI) begin
               partial_unit = {5'd0, b[4:0], 6'd0};
               cont_left    = CONT_ONE;
            end else if (b[7:4] == LEAD_THREE) begin
               partial_unit = {b[3:0], 12'd0};
               cont_left    = CONT_TWO;
            end else begin
               r.bad_char = 1'b1;
               r.last     = count_char();
               emit       = 1'b1;
            end
            if (r.last) restart();
         end
         default: begin
            accum = {accum[ACCUM_W-8:0], b[6:0]};
            if (b[7]) begin
               v = accum;
               if (v == '0) begin
                  r.empty_res = 1'b1;
                  r.last      = 1'b1;
                  emit        = 1'b1;
                  restart();
               end else if (v[COMPRESSOR_BITS-1:0] != '0) begin
                  r.bad_compression = 1'b1;
                  r.last            = 1'b1;
                  emit              = 1'b1;
                  restart();
               end else begin
                  // drop the compressor id and the flag bit above it
                  v     = v >> (COMPRESSOR_BITS + 1);
                  accum = '0;
                  if (!v[0]) begin
                     phase = PH_ASCII;
                  end else begin
                     chars_left   = (v > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
                                                    : v[COUNT_BITS-1:0];
                     partial_unit = '0;
                     cont_left    = CONT_NONE;
                     phase        = PH_UTF;
                  end
               end
            end
         end
      endcase
      if (emit) decoded_queue.insert(decoded_queue.size(), r);
   endtask

   always @(posedge clock) begin : watch
      decoded_type want;
      if (reset) begin
         restart();
         decoded_queue.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (decoded_queue.size() == 0) begin
               report_mismatch($sformatf("result with no request pending, code_unit %h",
                                         rsp_code_unit));
            end else begin
               want = decoded_queue.pop_front();
               if (rsp_code_unit !== want.unit)
                  report_mismatch($sformatf("code_unit %h, expected %h",
                                            rsp_code_unit, want.unit));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %b, expected %b", rsp_last, want.last));
               if (rsp_empty_res !== want.empty_res)
                  report_mismatch($sformatf("empty_res %b, expected %b",
                                            rsp_empty_res, want.empty_res));
               if (rsp_bad_compression !== want.bad_compression)
                  report_mismatch($sformatf("bad_compression %b, expected %b",
                                            rsp_bad_compression, want.bad_compression));
               if (rsp_bad_char !== want.bad_char)
                  report_mismatch($sformatf("bad_char %b, expected %b",
                                            rsp_bad_char, want.bad_char));
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) decode_byte(req_byte_value);
      end
      outstanding     = decoded_queue.size();
      at_string_start = (phase == PH_HEADER) && (accum == '0);
   end

endmodule

/* verif/testbench.sv */
// Testbench top for serialized_string_decoder_top: drives request bytes with random
// gaps and result stalls, and gives the verdict from string_decode_checker.
// Depends on ssd_pkg, the decoder RTL and verif/string_decode_checker.sv.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ssd_pkg::*;

   localparam int          STREAM_BYTES = 1120;
   localparam int          HOLD_BYTES   = 550;
   localparam int          END_WAIT     = 20;
   localparam logic [7:0]  STOP_BIT     = 8'h80;
   localparam logic [7:0]  CONT_TAG     = 8'h80;
   localparam logic [7:0]  TWO_LEAD     = 8'hC0;
   localparam logic [7:0]  THREE_LEAD   = 8'hE0;
   localparam logic [3:0]  BAD_NIB_LO   = 4'h8;
   localparam logic [3:0]  BAD_NIB_TOP  = 4'hF;

   logic              clock;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_stall;
   logic [BYTE_W-1:0] req_byte_value = '0;
   logic              rsp_valid;
   logic              rsp_stall      = 1'b0;
   logic [UNIT_W-1:0] rsp_code_unit;
   logic              rsp_last;
   logic              rsp_empty_res;
   logic              rsp_bad_compression;
   logic              rsp_bad_char;

   int   mismatch_count;
   int   outstanding;
   logic at_string_start;
   bit   quiet      = 1'b0;
   int   bytes_sent = 0;
   int   stall_left = 0;

   serialized_string_decoder_top uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_byte_value      (req_byte_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_code_unit       (rsp_code_unit),
      .rsp_last            (rsp_last),
      .rsp_empty_res       (rsp_empty_res),
      .rsp_bad_compression (rsp_bad_compression),
      .rsp_bad_char        (rsp_bad_char)
   );

   string_decode_checker decode_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_byte_value      (req_byte_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_code_unit       (rsp_code_unit),
      .rsp_last            (rsp_last),
      .rsp_empty_res       (rsp_empty_res),
      .rsp_bad_compression (rsp_bad_compression),
      .rsp_bad_char        (rsp_bad_char),
      .mismatch_count      (mismatch_count),
      .outstanding         (outstanding),
      .at_string_start     (at_string_start)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #20_000_000;
      $display("testbench failed");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_left = gap_len() - 1;
         rsp_stall <= 1'b1;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 9) < 3) gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_byte_value <= b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      bytes_sent++;
   endtask

   function automatic logic [7:0] cont_byte();
      if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
      return CONT_TAG | 8'($urandom_range(0, 63));
   endfunction

   task automatic send_header(input accum_type v, input int zeros);
      int n;
      n = 1;
      while (n < 10 && (v >> (7 * n)) != '0) n++;
      repeat (zeros) send_byte(8'h00);
      for (int i = n - 1; i >= 0; i--) send_byte({i == 0, 7'(v >> (7 * i))});
   endtask

   // First group is nonzero, so short headers never collapse to zero.
   task automatic send_groups(input int ngroups, input logic [6:0] last_group);
      for (int i = 0; i < ngroups - 1; i++)
         send_byte((i == 0) ? 8'($urandom_range(1, 127)) : 8'($urandom_range(0, 127)));
      send_byte(STOP_BIT | {1'b0, last_group});
   endtask

   task automatic send_ascii(input int len, input bit terminate);
      repeat (len) send_byte(8'($urandom_range(0, 127)));
      if (terminate) send_byte(STOP_BIT | 8'($urandom_range(0, 127)));
   endtask

   task automatic send_utf_chars(input int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: send_byte(8'($urandom_range(0, 127)));
            4, 5, 9: begin
               send_byte(TWO_LEAD | 8'($urandom_range(0, 31)));
               send_byte(cont_byte());
            end
            6, 7: begin
               send_byte(THREE_LEAD | 8'($urandom_range(0, 15)));
               send_byte(cont_byte());
               send_byte(cont_byte());
            end
            default: begin
               pick = $urandom_range(0, 4);
               send_byte({(pick == 4) ? BAD_NIB_TOP : BAD_NIB_LO + 4'(pick),
                          4'($urandom_range(0, 15))});
            end
         endcase
      end
   endtask

   initial begin : stimulus
      int         kind;
      int         n;
      int         m;
      int         zeros;
      bit         held_off;
      logic [6:0] lg;
      held_off = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty string, bad compressor id, ASCII selected by a zero value
      send_byte(8'h80);
      send_byte(8'h81);
      send_byte(8'h88); send_byte(8'h00); send_byte(8'h7F); send_byte(8'hFF);
      // three UTF characters: one, two and three bytes at their extremes
      send_byte(8'hB0); send_byte(8'h00); send_byte(8'hDF); send_byte(8'hBF);
      send_byte(8'hEF); send_byte(8'hBF); send_byte(8'hBF);
      // bad lead bytes, then a continuation with its top bits clear
      send_byte(8'hD0); send_byte(8'h80); send_byte(8'hBF); send_byte(8'hF0);
      send_byte(8'hFF); send_byte(8'hCA); send_byte(8'h00);
      // header with leading zero groups
      send_byte(8'h00); send_byte(8'h00); send_byte(8'h90); send_byte(8'h41);

      while (bytes_sent < STREAM_BYTES) begin
         // finish any broken string so the next header lands in the header phase
         while (!at_string_start) send_byte(STOP_BIT);
         if ($urandom_range(0, 19) == 0) quiet = !quiet;
         if (!held_off && bytes_sent >= HOLD_BYTES) begin
            held_off = 1'b1;
            req_valid <= 1'b0;
            wait (outstanding == 0);
            repeat (8) @(negedge clock);
         end
         zeros = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
         kind  = $urandom_range(0, 99);
         if (kind < 36) begin
            n = ($urandom_range(0, 7) == 0) ? 2 * $urandom_range(0, 31) + 1
                                            : 2 * $urandom_range(0, 7) + 1;
            send_header((accum_type'(n) << 4) | (accum_type'($urandom_range(0, 1)) << 3),
                        zeros);
            send_utf_chars(n);
         end else if (kind < 60) begin
            m = 2 * $urandom_range(0, 511);
            send_header((accum_type'(m) << 4) | (accum_type'($urandom_range(0, 1)) << 3),
                        zeros);
            send_ascii($urandom_range(0, 20), 1'b1);
         end else if (kind < 68) begin
            // long header: with ten or more groups, the oldest bits fall off the top of the accumulator
            send_groups($urandom_range(2, 11), 7'h20 | (7'($urandom_range(0, 127)) & 7'h68));
            send_ascii($urandom_range(0, 12), 1'b1);
         end else if (kind < 74) begin
            send_header('0, zeros);
         end else if (kind < 82) begin
            lg = 7'($urandom_range(0, 127));
            if (lg[2:0] == 3'd0) lg[2:0] = 3'($urandom_range(1, 7));
            send_groups($urandom_range(1, 11), lg);
         end else if (kind < 92) begin
            case ($urandom_range(0, 2))
               0: send_ascii($urandom_range(1, 2), 1'b0);
               1: begin
                  send_header(accum_type'(2 * $urandom_range(0, 63)) << 4, 0);
                  send_ascii($urandom_range(0, 6), 1'b0);
               end
               default: begin
                  n = 2 * $urandom_range(1, 7) + 1;
                  send_header(accum_type'(n) << 4, 0);
                  send_utf_chars($urandom_range(0, n - 1));
                  if ($urandom_range(0, 1) == 0)
                     send_byte(($urandom_range(0, 1) == 0) ? TWO_LEAD | 8'($urandom_range(0, 31))
                                                           : THREE_LEAD | 8'($urandom_range(0, 15)));
               end
            endcase
         end else begin
            // noise: single-group headers and terminators only, so counts stay small
            repeat ($urandom_range(1, 5)) send_byte(STOP_BIT | 8'($urandom_range(0, 127)));
         end
      end

      // count far above the counter width: saturates, so the string never ends
      while (!at_string_start) send_byte(STOP_BIT);
      send_groups(8, 7'h10 | (7'($urandom_range(0, 127)) & 7'h68));
      send_utf_chars(40);
      req_valid <= 1'b0;

      wait (outstanding == 0);
      repeat (END_WAIT) @(posedge clock);
      if (outstanding != 0) $display("%0d expected results never arrived", outstanding);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/ssd_pkg.sv
rtl/core/ssd_front.sv
rtl/core/ssd_queue.sv
rtl/core/ssd_back.sv
rtl/core/serialized_string_decoder_top.sv
verif/string_decode_checker.sv
verif/testbench.sv
